[src/ptno_pkg.sv]
// shared types and constants for the piezo trigger note on/off unit
// no dependencies; imported by piezo_trigger_note_on_off_unit
package ptno_pkg;

	// sensor inputs served and per-input state slots (index is two bits wide)
	localparam int NUM_INPUTS = 4;
	localparam int SLOTS      = 4;
	localparam int IDX_W      = $clog2(SLOTS);

	// converter full scale used for velocity scaling
	localparam int FULL_SCALE = 775;

	localparam logic [6:0] VEL_MAX = 7'd127;

	// velocity = floor(sample*127 / FULL_SCALE) by reciprocal multiply
	// ceil(2^27 / FULL_SCALE) is exact for every product below 2^17
	localparam int VEL_SHIFT   = 27;
	localparam int SCALED_W    = 17;
	localparam int VEL_RECIP_W = VEL_SHIFT + 1;
	localparam int VEL_PROD_W  = SCALED_W + VEL_RECIP_W;
	localparam int VEL_QUOT_W  = VEL_PROD_W - VEL_SHIFT;
	localparam logic [VEL_RECIP_W-1:0] VEL_RECIP =
		VEL_RECIP_W'((2 ** VEL_SHIFT + FULL_SCALE - 1) / FULL_SCALE);

	// configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_ON  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_OFF = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW        = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_0       = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_1       = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_2       = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_3       = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL       = 4'd7;
	localparam int CFG_DATA_W = 10;

	// register reset values
	localparam logic [9:0] THRESHOLD_ON_RST  = 10'd35;
	localparam logic [9:0] THRESHOLD_OFF_RST = 10'd16;
	localparam logic [7:0] WINDOW_RST        = 8'd8;
	localparam logic [6:0] PITCH_RST         = 7'd60;
	localparam logic [4:0] CHANNEL_RST       = 5'd1;

	// event kinds
	localparam logic EV_NOTE_ON  = 1'b0;
	localparam logic EV_NOTE_OFF = 1'b1;

	typedef struct packed {
		logic [1:0] input_index;
		logic [9:0] sample;
	} sample_word_t;

	typedef struct packed {
		logic       event_kind;
		logic [1:0] event_input;
		logic [6:0] pitch;
		logic [6:0] velocity;
		logic [4:0] note_channel;
	} note_event_t;

endpackage

[src/piezo_trigger_note_on_off_unit.sv]
// piezo trigger to note-on / note-off event generator, top level
// depends on ptno_pkg (types, register indexes, velocity scaling constants)

// Takes one converter sample word per cycle, tagged with its sensor input, and
// emits zero or one note event word per sample. An idle input whose sample
// reaches threshold_on emits a note-on with velocity sample*127/FULL_SCALE
// (saturated at 127) and starts playing; a playing input counts samples over a
// window of window_q samples and tracks their peak, and a window whose peak is at
// or below threshold_off emits a note-off and returns the input to idle.
// Throughput is one sample word per cycle while in_stall is low; a sample's
// event word is registered into the output register when the sample leaves
// the single stage, which reads and writes the per-input state (playing flag,
// window count, window peak) for the sample it holds and sets the rate, so a
// word for the same input in the next cycle sees the updated state. in_stall
// rises only when the stage holds a word that makes an event while the output
// register is full and stalled. The user must write configuration registers
// via cfg_we/cfg_index/cfg_data only while the block is idle; the block does
// not enforce it; writes to an index past the channel register are ignored.
module piezo_trigger_note_on_off_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [ptno_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ptno_pkg::CFG_DATA_W-1:0]     cfg_data,
	// sample words in
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ptno_pkg::sample_word_t              in_word,
	// note event words out
	output logic                                out_valid,
	input  logic                                out_stall,
	output ptno_pkg::note_event_t               out_word
);
	import ptno_pkg::*;

	// configuration registers
	logic [9:0] threshold_on_q;
	logic [9:0] threshold_off_q;
	logic [7:0] window_q;
	logic [6:0] pitch_q [SLOTS];
	logic [4:0] channel_q;

	// per-input state
	logic       playing_q [SLOTS];
	logic [7:0] count_q   [SLOTS];
	logic [9:0] peak_q    [SLOTS];

	// input register
	logic         valid_s1;
	sample_word_t word_s1;

	// result register
	logic        out_valid_q;
	note_event_t out_word_q;

	// stage logic
	logic [IDX_W-1:0]      idx;
	logic                  in_range;
	logic                  cur_playing;
	logic [7:0]            cnt_inc;
	logic [9:0]            peak_max;
	logic                  window_end;
	logic                  note_on;
	logic                  note_off;
	logic                  emit;
	logic                  out_free;
	logic                  adv;
	logic [SCALED_W-1:0]   scaled;
	logic [VEL_PROD_W-1:0] vel_prod;
	logic [VEL_QUOT_W-1:0] vel_quot;
	logic [6:0]            velocity;
	note_event_t           ev;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_on_q  <= THRESHOLD_ON_RST;
			threshold_off_q <= THRESHOLD_OFF_RST;
			window_q        <= WINDOW_RST;
			channel_q       <= CHANNEL_RST;
			for (int i = 0; i < SLOTS; i++) begin
				pitch_q[i] <= PITCH_RST;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD_ON:  threshold_on_q  <= cfg_data;
				REG_THRESHOLD_OFF: threshold_off_q <= cfg_data;
				REG_WINDOW:        window_q        <= cfg_data[7:0];
				REG_PITCH_0:       pitch_q[0]      <= cfg_data[6:0];
				REG_PITCH_1:       pitch_q[1]      <= cfg_data[6:0];
				REG_PITCH_2:       pitch_q[2]      <= cfg_data[6:0];
				REG_PITCH_3:       pitch_q[3]      <= cfg_data[6:0];
				REG_CHANNEL:       channel_q       <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// look up the state of the sample's input
	assign idx         = word_s1.input_index;
	assign in_range    = (int'(idx) < NUM_INPUTS);
	assign cur_playing = playing_q[idx];
	assign cnt_inc     = count_q[idx] + 8'd1;
	assign peak_max    = (word_s1.sample > peak_q[idx]) ? word_s1.sample : peak_q[idx];
	// a zero window length ends a window on every playing sample
	assign window_end  = (cnt_inc >= window_q);

	assign note_on  = in_range && !cur_playing && (word_s1.sample >= threshold_on_q);
	assign note_off = in_range && cur_playing && window_end && (peak_max <= threshold_off_q);
	assign emit     = note_on || note_off;

	// velocity: sample*127 by shift-subtract, then reciprocal multiply
	assign scaled   = {word_s1.sample, 7'd0} - {7'd0, word_s1.sample};
	assign vel_prod = VEL_PROD_W'(scaled) * VEL_PROD_W'(VEL_RECIP);
	assign vel_quot = vel_prod[VEL_PROD_W-1:VEL_SHIFT];
	assign velocity = (vel_quot > VEL_QUOT_W'(VEL_MAX)) ? VEL_MAX : vel_quot[6:0];

	always_comb begin
		ev.event_kind   = note_off ? EV_NOTE_OFF : EV_NOTE_ON;
		ev.event_input  = idx;
		ev.pitch        = pitch_q[idx];
		ev.velocity     = note_off ? 7'd0 : velocity;
		ev.note_channel = channel_q;
	end

	// the stage moves on unless its event has nowhere to go
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !adv;

	// per-input state update, only when the word leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				playing_q[i] <= 1'b0;
				count_q[i]   <= 8'd0;
				peak_q[i]    <= 10'd0;
			end
		end else if (adv && in_range) begin
			if (!cur_playing) begin
				if (note_on) begin
					playing_q[idx] <= 1'b1;
					count_q[idx]   <= 8'd1;
					peak_q[idx]    <= 10'd0;
				end
			end else if (window_end) begin
				count_q[idx] <= 8'd0;
				peak_q[idx]  <= 10'd0;
				if (note_off) begin
					playing_q[idx] <= 1'b0;
				end
			end else begin
				count_q[idx] <= cnt_inc;
				peak_q[idx]  <= peak_max;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1 && emit) begin
			out_word_q <= ev;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef SYNTHESIS
	// a note-off never carries a velocity
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.event_kind == EV_NOTE_OFF) |-> (out_word.velocity == 7'd0))
		else $error("note-off word with nonzero velocity");

	// a committed note-on leaves its input playing
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && note_on |=> playing_q[$past(idx)])
		else $error("input not playing after note-on");

	// input side only stalls behind a held word
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && emit && out_valid_q)
		else $error("input stalled without a blocked event");
`endif

endmodule
